// ===== design/spq_pkg.sv =====
// Shared types, constants and compare function of the stable priority task queue.
package spq_pkg;

	localparam int PRIO_W  = 8;
	localparam int TAG_W   = 16;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		OP_ENQUEUE = 2'd0,
		OP_PEEK    = 2'd1,
		OP_POP     = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	// One stored task
	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic              pre;
		logic [TAG_W-1:0]  tag;
	} spq_entry_t;

	// Command item
	typedef struct packed {
		logic [1:0]        operation;
		logic [PRIO_W-1:0] task_priority;
		logic              task_preemptive;
		logic [TAG_W-1:0]  task_tag;
	} spq_cmd_t;

	// Response item
	typedef struct packed {
		logic              head_valid;
		logic [PRIO_W-1:0] out_priority;
		logic              out_preemptive;
		logic [TAG_W-1:0]  out_tag;
		logic              overflow;
		logic [COUNT_W-1:0] entry_count;
	} spq_rsp_t;

	// Broadcast control to every cell of the chain
	typedef struct packed {
		logic enq;
		logic pop;
	} spq_cell_ctrl_t;

	// New task sorts ahead of the stored one
	function automatic logic goes_before(spq_entry_t nw, spq_entry_t old);
		logic res;
		if (nw.prio != old.prio) begin
			res = nw.prio > old.prio;
		end else begin
			res = nw.pre && !old.pre;
		end
		return res;
	endfunction

endpackage

// ===== design/spq_cell.sv =====
// One compare-and-shift cell of the sorted queue chain.
module spq_cell (
	input  logic                   clk,
	input  spq_pkg::spq_cell_ctrl_t ctrl,
	input  logic                   occ,
	input  spq_pkg::spq_entry_t    new_entry,
	input  spq_pkg::spq_entry_t    prev_entry,
	input  logic                   prev_ahead,
	input  spq_pkg::spq_entry_t    next_entry,
	output spq_pkg::spq_entry_t    entry_q,
	output logic                   ahead
);
	import spq_pkg::*;

	// Empty slots always take part in the shift on insert
	assign ahead = !occ || goes_before(new_entry, entry_q);

	// Insert: shift down from neighbor or take the new task; pop: shift up
	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			if (ahead) begin
				entry_q <= prev_ahead ? prev_entry : new_entry;
			end
		end else if (ctrl.pop) begin
			entry_q <= next_entry;
		end
	end

endmodule

// ===== design/spq_out_buf.sv =====
// Response register with a skid stage so a new item can be taken while one waits.
module spq_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  spq_pkg::spq_rsp_t push_data,
	output logic              full,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output spq_pkg::spq_rsp_t rsp
);
	import spq_pkg::*;

	logic     main_valid_q;
	logic     skid_valid_q;
	spq_rsp_t main_q;
	spq_rsp_t skid_q;
	logic     take;

	assign take      = main_valid_q && !rsp_stall;
	assign full      = skid_valid_q;
	assign rsp_valid = main_valid_q;
	assign rsp       = main_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

// ===== design/stable_priority_task_queue.sv =====
// Top level: sorted task queue as a chain of compare-and-shift cells.
// Each accepted command item has its response registered in the output buffer, in its main or skid register.
// One item per cycle while cmd_stall is low; every cell compares against the broadcast task
// and shifts by one slot in the same cycle, for insert and pop alike.
// Up to two responses are buffered; cmd_stall rises when both are held.
// Reset (arst_n low) empties the queue and the response buffer; slot contents are not cleared.
module stable_priority_task_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  spq_pkg::spq_cmd_t cmd,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output spq_pkg::spq_rsp_t rsp
);
	import spq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_next;
	logic                  accept;
	logic                  full;
	logic                  empty;
	logic                  buf_full;
	spq_cell_ctrl_t        ctrl;
	spq_entry_t            new_entry;
	spq_entry_t            ent [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] ahead;
	logic [QUEUE_DEPTH-1:0] occ;
	spq_rsp_t              res;

	assign cmd_stall = buf_full;
	assign accept    = cmd_valid && !buf_full;
	assign full      = count_q == CW'(QUEUE_DEPTH);
	assign empty     = count_q == '0;

	assign new_entry.prio = cmd.task_priority;
	assign new_entry.pre  = cmd.task_preemptive;
	assign new_entry.tag  = cmd.task_tag;

	// Cell control and count update
	always_comb begin
		ctrl.enq   = 1'b0;
		ctrl.pop   = 1'b0;
		count_next = count_q;
		if (accept) begin
			unique case (op_t'(cmd.operation))
				OP_ENQUEUE: begin
					if (!full) begin
						ctrl.enq   = 1'b1;
						count_next = count_q + CW'(1);
					end
				end
				OP_POP: begin
					if (!empty) begin
						ctrl.pop   = 1'b1;
						count_next = count_q - CW'(1);
					end
				end
				OP_PEEK:  count_next = count_q;
				OP_CLEAR: count_next = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// Response for the accepted item
	always_comb begin
		res             = '0;
		res.entry_count = COUNT_W'(count_next);
		unique case (op_t'(cmd.operation))
			OP_ENQUEUE: res.overflow = full;
			OP_PEEK, OP_POP: begin
				if (!empty) begin
					res.head_valid     = 1'b1;
					res.out_priority   = ent[0].prio;
					res.out_preemptive = ent[0].pre;
					res.out_tag        = ent[0].tag;
				end
			end
			OP_CLEAR: res.overflow = 1'b0;
		endcase
	end

	// Cell chain
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		spq_entry_t prev_e;
		spq_entry_t next_e;
		logic       prev_b;

		assign occ[i] = CW'(i) < count_q;

		if (i == 0) begin : g_first
			assign prev_e = new_entry;
			assign prev_b = 1'b0;
		end else begin : g_mid
			assign prev_e = ent[i-1];
			assign prev_b = ahead[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign next_e = new_entry;
		end else begin : g_inner
			assign next_e = ent[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occ         (occ[i]),
			.new_entry   (new_entry),
			.prev_entry  (prev_e),
			.prev_ahead  (prev_b),
			.next_entry  (next_e),
			.entry_q     (ent[i]),
			.ahead       (ahead[i])
		);
	end

	spq_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res),
		.full      (buf_full),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== design/spq_checker.sv =====
// Port-level checks of the task queue and their binding to the top level.
module spq_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_stall,
	input spq_pkg::spq_cmd_t cmd,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input spq_pkg::spq_rsp_t rsp
);
	import spq_pkg::*;

	// Stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// After every accepted item a response is valid in the next cycle
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> rsp_valid)
		else $error("no response after accepted item");

	// Command side only stalls with responses pending
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |=> !cmd_stall)
		else $error("stall without buffered responses");

	// Clear taken with an empty buffer reports an empty queue next cycle
	a_clear_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && !rsp_valid && cmd.operation == OP_CLEAR
		|=> rsp.entry_count == '0 && !rsp.head_valid && !rsp.overflow)
		else $error("clear response not empty");

endmodule

bind stable_priority_task_queue spq_checker u_spq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd       (cmd),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
